// ===== hw/rtl/jked_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick key event debouncer package
// Shared payload types, register indexes, key codes and event slot layout.
// ----------------------------------------------------------------------------
package jked_pkg;

  // Fixed field widths.
  localparam int unsigned AXIS_W     = 12;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned KEY_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Event slots per poll: eight directions, fire, three buttons.
  localparam int unsigned NUM_DIR     = 8;
  localparam int unsigned NUM_BTN     = 3;
  localparam int unsigned NUM_EVT     = 12;
  localparam int unsigned EVT_IDX_W   = 4;
  localparam int unsigned EVT_FIRE    = 8;
  localparam int unsigned EVT_BTN_LO  = 9;

  // Register reset values.
  localparam logic [AXIS_W-1:0]  THR_LOW_RST  = 12'd800;
  localparam logic [AXIS_W-1:0]  THR_HIGH_RST = 12'd3200;
  localparam logic [LIMIT_W-1:0] DEB_ESC_RST  = 8'd5;
  localparam logic [LIMIT_W-1:0] DEB_WPN_RST  = 8'd3;
  localparam logic [LIMIT_W-1:0] DEB_USE_RST  = 8'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_LOW  = 3'd0,
    CFG_THR_HIGH = 3'd1,
    CFG_DEB_ESC  = 3'd2,
    CFG_DEB_WPN  = 3'd3,
    CFG_DEB_USE  = 3'd4
  } cfg_reg_e;

  // Key codes.
  typedef enum logic [KEY_W-1:0] {
    KEY_RIGHT    = 3'd0,
    KEY_LEFT     = 3'd1,
    KEY_FORWARD  = 3'd2,
    KEY_BACKWARD = 3'd3,
    KEY_SHOOT    = 3'd4,
    KEY_MENU     = 3'd5,
    KEY_WEAPON   = 3'd6,
    KEY_USE      = 3'd7
  } key_code_e;

  // One poll of the controller.
  typedef struct packed {
    logic [AXIS_W-1:0] stick1_x;
    logic [AXIS_W-1:0] stick1_y;
    logic [AXIS_W-1:0] stick2_x;
    logic [AXIS_W-1:0] stick2_y;
    logic              escape_pressed;
    logic              weapon_pressed;
    logic              stick1_pressed;
    logic              stick2_pressed;
    logic              use_pressed;
  } poll_t;

  // One key event.
  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic             is_press;
    logic             last_event;
  } key_evt_t;

  // Events found by the lanes for one poll, one slot per lane.
  typedef struct packed {
    logic [NUM_EVT-1:0] mask;
    logic [NUM_EVT-1:0] down;
  } evt_set_t;

  // Key code carried by an event slot.
  function automatic logic [KEY_W-1:0] slot_code(logic [EVT_IDX_W-1:0] idx);
    logic [KEY_W-1:0] code;
    unique case (idx)
      4'd8:    code = KEY_SHOOT;
      4'd9:    code = KEY_MENU;
      4'd10:   code = KEY_WEAPON;
      4'd11:   code = KEY_USE;
      default: code = {1'b0, idx[1:0]};
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/joystick_key_event_debouncer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick key event debouncer
// Turns polls of two analog sticks and five buttons into key press and
// release events.
// ----------------------------------------------------------------------------
// Usage:
// A poll transfers on the in channel (in_valid_i / in_ready_o). Eight axis
// lanes, a fire flag and three debounce lanes evaluate it in the same cycle
// and update their state at the transfer. The merge stage then sends the
// resulting 0 to 12 events on the out channel, one per cycle while the receiver
// is ready, in slot order (directions, fire, escape, weapon, use); last_event
// marks a poll's final event. A poll with no events produces no transfer at all.
// A poll's events are registered in the drain bank at the transfer, or first
// in the holding bank while the drain bank is busy. Polls without events are
// taken whenever the holding bank is empty.
// A second poll is held in a holding bank while the first drains; in_ready_o
// drops only while that bank is occupied. When the receiver stalls, the
// current event holds, one further poll with events is held, and polls
// without events keep transferring until such a poll fills the holding bank.
// Configuration writes (cfg_valid_i, always ready) apply on the next cycle;
// indexes beyond the last register are ignored.
// Reset clears all direction, fire and button state and loads the default
// thresholds and debounce limits.
// ----------------------------------------------------------------------------
module joystick_key_event_debouncer #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  jked_pkg::poll_t                 in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output jked_pkg::key_evt_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jked_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jked_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import jked_pkg::*;

  logic [AXIS_W-1:0]  thr_low_q;
  logic [AXIS_W-1:0]  thr_high_q;
  logic [LIMIT_W-1:0] limit_q [NUM_BTN];
  logic               fire_q;
  logic               fire_now;
  logic               accept;
  logic [AXIS_W-1:0]  axis [4];
  logic [NUM_BTN-1:0] raw_btn;
  evt_set_t           evt;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_low_q  <= THR_LOW_RST;
      thr_high_q <= THR_HIGH_RST;
      limit_q[0] <= DEB_ESC_RST;
      limit_q[1] <= DEB_WPN_RST;
      limit_q[2] <= DEB_USE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_THR_LOW:  thr_low_q  <= cfg_data_i[AXIS_W-1:0];
        CFG_THR_HIGH: thr_high_q <= cfg_data_i[AXIS_W-1:0];
        CFG_DEB_ESC:  limit_q[0] <= cfg_data_i[LIMIT_W-1:0];
        CFG_DEB_WPN:  limit_q[1] <= cfg_data_i[LIMIT_W-1:0];
        CFG_DEB_USE:  limit_q[2] <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign axis[0] = in_data_i.stick1_x;
  assign axis[1] = in_data_i.stick1_y;
  assign axis[2] = in_data_i.stick2_x;
  assign axis[3] = in_data_i.stick2_y;

  // Direction lanes: per stick right, left, forward, backward.
  for (genvar i = 0; i < NUM_DIR; i++) begin : g_dir
    localparam int unsigned STICK = i / 4;
    localparam int unsigned DIR   = i % 4;
    localparam int unsigned AXIS  = STICK * 2 + DIR / 2;
    localparam logic        LOW   = (DIR == 1) || (DIR == 2);

    jked_axis_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .sample_i   (axis[AXIS]),
      .thr_low_i  (thr_low_q),
      .thr_high_i (thr_high_q),
      .low_side_i (LOW),
      .accept_i   (accept),
      .event_o    (evt.mask[i]),
      .down_o     (evt.down[i])
    );
  end

  // Fire follows the OR of both stick push buttons.
  assign fire_now           = in_data_i.stick1_pressed || in_data_i.stick2_pressed;
  assign evt.mask[EVT_FIRE] = fire_now != fire_q;
  assign evt.down[EVT_FIRE] = fire_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fire_q <= 1'b0;
    end else if (accept) begin
      fire_q <= fire_now;
    end
  end

  // Debounced button lanes: escape, weapon, use.
  assign raw_btn = {in_data_i.use_pressed, in_data_i.weapon_pressed,
                    in_data_i.escape_pressed};

  for (genvar j = 0; j < NUM_BTN; j++) begin : g_btn
    jked_btn_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .raw_i    (raw_btn[j]),
      .limit_i  (limit_q[j]),
      .accept_i (accept),
      .event_o  (evt.mask[EVT_BTN_LO + j]),
      .down_o   (evt.down[EVT_BTN_LO + j])
    );
  end

  // Merge the lane results and serialize them.
  jked_evt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt),
    .accept_i    (accept),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/jked_axis_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis direction lane
// Compares one axis sample against a threshold and flags a change of the
// direction's active state.
// ----------------------------------------------------------------------------
module jked_axis_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [jked_pkg::AXIS_W-1:0]  sample_i,
  input  logic [jked_pkg::AXIS_W-1:0]  thr_low_i,
  input  logic [jked_pkg::AXIS_W-1:0]  thr_high_i,
  input  logic                         low_side_i,
  input  logic                         accept_i,
  output logic                         event_o,
  output logic                         down_o
);
  import jked_pkg::*;

  logic active_q;
  logic active_now;

  // Up and left sit below the low threshold, down and right above the high one.
  assign active_now = low_side_i ? (sample_i < thr_low_i) : (sample_i > thr_high_i);
  assign event_o    = active_now != active_q;
  assign down_o     = active_now;

  // Direction state follows each accepted poll.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (accept_i) begin
      active_q <= active_now;
    end
  end

endmodule

// ===== hw/rtl/jked_btn_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce lane
// Counts stable polls of one button and registers a change once the count
// reaches the configured limit.
// ----------------------------------------------------------------------------
module jked_btn_lane #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         raw_i,
  input  logic [jked_pkg::LIMIT_W-1:0] limit_i,
  input  logic                         accept_i,
  output logic                         event_o,
  output logic                         down_o
);
  import jked_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  prev_q;
  logic                  reg_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [COUNT_BITS-1:0] count_d;
  logic [CMP_W-1:0]      count_ext;
  logic [CMP_W-1:0]      count_d_ext;
  logic [CMP_W-1:0]      limit_ext;

  assign count_ext   = CMP_W'(count_q);
  assign count_d_ext = CMP_W'(count_d);
  assign limit_ext   = CMP_W'(limit_i);

  // A change of the raw level restarts the count; otherwise it counts up, saturating at the limit or at its maximum.
  always_comb begin
    count_d = count_q;
    if (raw_i != prev_q) begin
      count_d = '0;
    end else if ((count_ext < limit_ext) && (count_q != COUNT_MAX)) begin
      count_d = count_q + COUNT_BITS'(1);
    end
  end

  // A stable level that differs from the registered one becomes an event.
  assign event_o = (count_d_ext == limit_ext) && (raw_i != reg_q);
  assign down_o  = raw_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      reg_q   <= 1'b0;
      count_q <= '0;
    end else if (accept_i) begin
      prev_q  <= raw_i;
      count_q <= count_d;
      if (event_o) begin
        reg_q <= raw_i;
      end
    end
  end

endmodule

// ===== hw/rtl/jked_evt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event merge and serializer
// Collects a poll's lane results and sends them one event per cycle while the
// receiver is ready, in slot order, with a holding bank so the next poll can be taken meanwhile.
// ----------------------------------------------------------------------------
module jked_evt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jked_pkg::evt_set_t   evt_i,
  input  logic                 accept_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output jked_pkg::key_evt_t   out_data_o
);
  import jked_pkg::*;

  logic [NUM_EVT-1:0]   mask_a_q, mask_a_d;
  logic [NUM_EVT-1:0]   down_a_q, down_a_d;
  logic [NUM_EVT-1:0]   mask_b_q, mask_b_d;
  logic [NUM_EVT-1:0]   down_b_q, down_b_d;
  logic [NUM_EVT-1:0]   low_bit;
  logic [EVT_IDX_W-1:0] sel_idx;
  logic                 last;
  logic                 out_xfer;
  logic                 a_free;

  // Lowest pending slot goes out first.
  assign low_bit = mask_a_q & (~mask_a_q + {{(NUM_EVT-1){1'b0}}, 1'b1});
  assign last    = (mask_a_q & ~low_bit) == '0;

  always_comb begin
    sel_idx = '0;
    for (int k = NUM_EVT - 1; k >= 0; k--) begin
      if (mask_a_q[k]) begin
        sel_idx = EVT_IDX_W'(k);
      end
    end
  end

  assign out_valid_o           = mask_a_q != '0;
  assign out_data_o.key_code   = slot_code(sel_idx);
  assign out_data_o.is_press   = down_a_q[sel_idx];
  assign out_data_o.last_event = last;

  assign out_xfer = out_valid_o && out_ready_i;
  assign a_free   = (mask_a_q == '0) || (out_xfer && last);
  assign ready_o  = mask_b_q == '0;

  // Bank A drains; bank B holds the next poll until A is free.
  always_comb begin
    mask_a_d = mask_a_q;
    down_a_d = down_a_q;
    mask_b_d = mask_b_q;
    down_b_d = down_b_q;
    if (a_free) begin
      if (mask_b_q != '0) begin
        mask_a_d = mask_b_q;
        down_a_d = down_b_q;
        mask_b_d = '0;
      end else begin
        mask_a_d = accept_i ? evt_i.mask : '0;
        down_a_d = evt_i.down;
      end
    end else begin
      if (out_xfer) begin
        mask_a_d = mask_a_q & ~low_bit;
      end
      if (accept_i) begin
        mask_b_d = evt_i.mask;
        down_b_d = evt_i.down;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_a_q <= '0;
      mask_b_q <= '0;
    end else begin
      mask_a_q <= mask_a_d;
      mask_b_q <= mask_b_d;
    end
  end

  // Event flags need no reset.
  always_ff @(posedge clk_i) begin
    down_a_q <= down_a_d;
    down_b_q <= down_b_d;
  end

  // The holding bank is only ever filled behind a draining bank.
  a_hold_behind_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_b_q != '0) |-> (mask_a_q != '0))
    else $error("holding bank occupied while drain bank is empty");

  // A poll does not end before its last event is sent.
  a_poll_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !last) |=> out_valid_o)
    else $error("event stream stopped before the last event");

  // A held poll stays put while the drain bank is busy.
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mask_b_q != '0) && !a_free) |=> $stable(mask_b_q))
    else $error("held poll changed while waiting");

endmodule
